@@ rtl/core/fpnd_pkg.sv @@
// shared types, codes and the reciprocal seed table of the newton divider
`default_nettype none

package fpnd_pkg;

  // input beat: dividend and divisor words
  typedef struct packed {
    logic [31:0] numerator_bits;
    logic [31:0] denominator_bits;
  } in_t;

  // output beat: quotient word and status code
  typedef struct packed {
    logic [31:0] quotient_bits;
    logic [1:0]  status;
  } out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_SCALE,
    ST_MUL
  } state_e;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIV0 = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  // configuration register indexes
  localparam logic CFG_SIGNED_MODE = 1'b0;
  localparam logic CFG_Q_FORMAT    = 1'b1;

  // reset values of the configuration registers
  localparam logic       SIGNED_MODE_RST = 1'b1;
  localparam logic [4:0] Q_FORMAT_RST    = 5'd15;

  // saturation words and the q31 constant one
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;
  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  // sequencer counts
  localparam int unsigned NORM_STEPS = 5;
  localparam int unsigned MUL_STEPS  = 7;
  localparam logic [2:0]  NORM_LAST  = 3'(NORM_STEPS - 1);
  localparam logic [2:0]  MUL_LAST   = 3'(MUL_STEPS - 1);

  // q6 seed of 1/d for d in [0.5,1), indexed by d bits 29:24
  localparam logic [7:0] SEED_TAB [64] = '{
    8'h7F, 8'h7D, 8'h7B, 8'h79, 8'h78, 8'h76, 8'h74, 8'h73,
    8'h71, 8'h6F, 8'h6E, 8'h6D, 8'h6B, 8'h6A, 8'h68, 8'h67,
    8'h66, 8'h65, 8'h63, 8'h62, 8'h61, 8'h60, 8'h5F, 8'h5E,
    8'h5D, 8'h5C, 8'h5B, 8'h5A, 8'h59, 8'h58, 8'h57, 8'h56,
    8'h55, 8'h54, 8'h53, 8'h52, 8'h52, 8'h51, 8'h50, 8'h4F,
    8'h4E, 8'h4E, 8'h4D, 8'h4C, 8'h4C, 8'h4B, 8'h4A, 8'h49,
    8'h49, 8'h48, 8'h48, 8'h47, 8'h46, 8'h46, 8'h45, 8'h45,
    8'h44, 8'h43, 8'h43, 8'h42, 8'h42, 8'h41, 8'h41, 8'h40
  };

  // seed guess as a q30 word
  function automatic logic [31:0] seed_guess(input logic [5:0] idx);
    seed_guess = {SEED_TAB[idx], 24'd0};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fpnd_frac_mul.sv @@
// shared q31 fractional multiplier: (a*b)>>31 truncated to 32 bits
`default_nettype none

module fpnd_frac_mul (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] p_o
);

  logic [63:0] prod;

  // full product, keep bits 62:31
  assign prod = 64'(a_i) * 64'(b_i);
  assign p_o  = prod[62:31];

endmodule

`default_nettype wire

@@ rtl/core/fixed_point_newton_divider_unit.sv @@
// Fixed-point Newton-Raphson divider, one item at a time over a shared multiplier.
// An item is taken when start is high and busy is low. A zero divisor answers
// on done_o in the cycle after the accept. Otherwise the divisor goes through a
// leading-zero search (shifts of 16, 8, 4, 2, 1 bits), a step of numerator
// scaling and seed lookup, then seven dependent multiplies on the one 32x32
// multiplier; the result is registered onto done_o after the last multiply (or
// after the scaling step when the scaled numerator overflows), and busy is
// already low when it shows. done_o lasts one cycle and cannot be held off;
// results must be taken when shown. Configuration writes take effect at once
// and are meant for idle periods only.
`default_nettype none

module fixed_point_newton_divider_unit
  import fpnd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [4:0] cfg_data_i,
  // command side
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_i,
  // result side
  output logic            done_o,
  output out_t            out_o
);

  // control bundle from the sequencer
  typedef struct packed {
    logic load;
    logic norm;
    logic scale;
    logic mul;
  } ctrl_t;

  state_e      state_q, state_d;
  ctrl_t       ctrl;
  logic [2:0]  cnt_q, cnt_d;

  logic        signed_mode_q;
  logic [4:0]  q_format_q;

  logic [31:0] mag_q;       // divisor magnitude, then normalized divisor
  logic [63:0] num_q;       // numerator, shifted along, then scaled
  logic [31:0] g_q;         // reciprocal guess
  logic [31:0] t_q;         // newton correction term
  logic        neg_q;

  logic        accept;
  logic        den_zero;
  logic [31:0] den_mag, num_mag;
  logic [31:0] norm_mask;
  logic [4:0]  norm_sh;
  logic        norm_take;
  logic [63:0] num_scaled;
  logic        num_ovf;
  logic [31:0] mul_b, mul_p;
  logic [31:0] t_next;
  logic        mul_last;

  logic        done_q;
  out_t        out_q;

  assign accept   = start && !busy;
  assign den_zero = (in_i.denominator_bits == '0);
  assign mul_last = (cnt_q == MUL_LAST);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= SIGNED_MODE_RST;
      q_format_q    <= Q_FORMAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        CFG_Q_FORMAT:    q_format_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && !den_zero) state_d = ST_NORM;
      end
      ST_NORM: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == NORM_LAST) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cnt_d   = '0;
        state_d = num_ovf ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 3'd1;
        if (mul_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = accept;
      end
      ST_NORM:  ctrl.norm  = 1'b1;
      ST_SCALE: ctrl.scale = 1'b1;
      ST_MUL:   ctrl.mul   = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // operand magnitudes in signed mode
  assign den_mag = (signed_mode_q && in_i.denominator_bits[31]) ?
                   (32'd0 - in_i.denominator_bits) : in_i.denominator_bits;
  assign num_mag = (signed_mode_q && in_i.numerator_bits[31]) ?
                   (32'd0 - in_i.numerator_bits) : in_i.numerator_bits;

  // one leading-zero search step per cycle
  always_comb begin
    case (cnt_q)
      3'd0:    begin norm_mask = 32'hFFFF_0000; norm_sh = 5'd16; end
      3'd1:    begin norm_mask = 32'hFF00_0000; norm_sh = 5'd8;  end
      3'd2:    begin norm_mask = 32'hF000_0000; norm_sh = 5'd4;  end
      3'd3:    begin norm_mask = 32'hC000_0000; norm_sh = 5'd2;  end
      default: begin norm_mask = 32'h8000_0000; norm_sh = 5'd1;  end
    endcase
  end
  assign norm_take = ((mag_q & norm_mask) == '0);

  // numerator holds num << clz(den); drop the 31-q excess fraction bits
  assign num_scaled = num_q >> (5'd31 - q_format_q);
  assign num_ovf    = (num_scaled[63:32] != '0);

  // shared multiplier operands: guess times divisor, correction or numerator
  always_comb begin
    if (mul_last)        mul_b = num_q[31:0];
    else if (!cnt_q[0])  mul_b = mag_q;
    else                 mul_b = t_q;
  end

  fpnd_frac_mul u_mul (
    .a_i (g_q),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // correction term: 2 - g*d in q30, shifted to q31
  assign t_next = {31'(Q31_ONE - mul_p), 1'b0};

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      mag_q <= den_mag;
      num_q <= {32'd0, num_mag};
      neg_q <= signed_mode_q &&
               (in_i.denominator_bits[31] ^ in_i.numerator_bits[31]);
    end
    if (ctrl.norm && norm_take) begin
      mag_q <= mag_q << norm_sh;
      num_q <= num_q << norm_sh;
    end
    if (ctrl.scale) begin
      mag_q <= mag_q >> 1;
      num_q <= num_scaled;
      g_q   <= seed_guess(mag_q[30:25]);
    end
    if (ctrl.mul && !mul_last) begin
      if (!cnt_q[0]) t_q <= t_next;
      else           g_q <= mul_p;
    end
  end

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (ctrl.load && den_zero) || (ctrl.scale && num_ovf) ||
                (ctrl.mul && mul_last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load && den_zero) begin
      out_q.quotient_bits <= MAX_POS;
      out_q.status        <= STATUS_DIV0;
    end else if (ctrl.scale && num_ovf) begin
      out_q.quotient_bits <= neg_q ? MIN_NEG : MAX_POS;
      out_q.status        <= STATUS_SAT;
    end else if (ctrl.mul && mul_last) begin
      if (signed_mode_q && mul_p[31]) begin
        out_q.quotient_bits <= neg_q ? MIN_NEG : MAX_POS;
        out_q.status        <= STATUS_SAT;
      end else begin
        out_q.quotient_bits <= neg_q ? (32'd0 - mul_p) : mul_p;
        out_q.status        <= STATUS_OK;
      end
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/fpnd_checker.sv @@
// port-level checks of the newton divider and their binding to the top level
`default_nettype none

module fpnd_checker
  import fpnd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire in_t  in_i,
  input wire logic done_o,
  input wire out_t out_o
);

  // zero divisor answers on the next cycle
  a_div0_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_i.denominator_bits == '0) |=>
      done_o && (out_o.status == STATUS_DIV0))
    else $error("zero divisor beat not answered next cycle");

  // a real division keeps the unit busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_i.denominator_bits != '0) |=> busy && !done_o)
    else $error("unit not busy after accepting a division");

  // divide by zero carries the largest positive word
  a_div0_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (out_o.status == STATUS_DIV0) |-> (out_o.quotient_bits == MAX_POS))
    else $error("divide by zero beat with wrong quotient");

  // saturated beats carry an extreme word
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (out_o.status == STATUS_SAT) |->
      (out_o.quotient_bits == MAX_POS) || (out_o.quotient_bits == MIN_NEG))
    else $error("saturated beat with non-extreme quotient");

endmodule

bind fixed_point_newton_divider_unit fpnd_checker u_fpnd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .in_i   (in_i),
  .done_o (done_o),
  .out_o  (out_o)
);

`default_nettype wire
